@@ rtl/indexed_array_list_unit_assert.svh @@
// Assertion macros used by the RTL.
`ifndef INDEXED_ARRAY_LIST_UNIT_ASSERT_SVH
`define INDEXED_ARRAY_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IAU_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IAU_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/iau_pkg.sv @@
`default_nettype none

package iau_pkg;

  localparam int POS_W     = 7;
  localparam int NUM_W     = 32;
  localparam int PAY_W     = 32;
  localparam int CNT_OUT_W = 7;
  localparam int ENTRY_W   = NUM_W + PAY_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BOUNDS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MOVE,
    S_PLACE,
    S_READ,
    S_RDATA,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/iau_ram.sv @@
`default_nettype none

module iau_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/indexed_array_list_unit.sv @@
// Sequence: S_EVAL sends a rejected or unused command straight to S_DONE, a read through S_READ
//   and S_RDATA, a delete through S_MOVE and an insert through S_MOVE and S_PLACE to S_DONE.
// Throughput: one transaction at a time, the next one taken at the edge that ends the
//   strobe cycle; each moved entry takes one RAM read and one RAM write.
// Reset: synchronous, active low; list empties, entry RAM contents are not cleared.
`default_nettype none

module indexed_array_list_unit #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_entry_number,
  input  logic [31:0]        in_entry_payload,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_read_number,
  output logic [31:0]        out_read_payload,
  output logic [6:0]         out_count,
  output logic               out_is_empty,
  output logic signed [6:0]  out_last_position
);

  import iau_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  state_t             state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [PAY_W-1:0]   pay_r, pay_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]      wr_addr_r, wr_addr_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [NUM_W-1:0]   rnum_r, rnum_nxt;
  logic [PAY_W-1:0]   rpay_r, rpay_nxt;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [NUM_W-1:0]   out_rnum_r;
  logic [PAY_W-1:0]   out_rpay_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic               out_empty_r;
  logic [CNT_OUT_W-1:0] out_last_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [PW-1:0]      pos_ext, cnt_ext, pos_p1, last_ext;
  logic [CW-1:0]      cnt_m1;
  logic [AW-1:0]      pos_addr;
  logic               is_ins;

  iau_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pos_ext  = PW'(pos_r);
  assign cnt_ext  = PW'(count_r);
  assign pos_p1   = pos_ext + 1'b1;
  assign cnt_m1   = count_r - 1'b1;
  assign pos_addr = pos_ext[AW-1:0];
  assign is_ins   = (cmd_r == CMD_INSERT);
  assign last_ext = PW'(count_nxt) - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    pos_r     <= pos_nxt;
    num_r     <= num_nxt;
    pay_r     <= pay_nxt;
    rem_r     <= rem_nxt;
    rd_idx_r  <= rd_idx_nxt;
    wr_addr_r <= wr_addr_nxt;
    status_r  <= status_nxt;
    rnum_r    <= rnum_nxt;
    rpay_r    <= rpay_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    pos_nxt     = pos_r;
    num_nxt     = num_r;
    pay_nxt     = pay_r;
    count_nxt   = count_r;
    rem_nxt     = rem_r;
    rd_idx_nxt  = rd_idx_r;
    wr_pend_nxt = wr_pend_r;
    wr_addr_nxt = wr_addr_r;
    status_nxt  = status_r;
    rnum_nxt    = rnum_r;
    rpay_nxt    = rpay_r;
    ram_we      = 1'b0;
    ram_waddr   = wr_addr_r;
    ram_wdata   = ram_rdata;
    ram_raddr   = rd_idx_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_cmd;
          pos_nxt     = in_position;
          num_nxt     = in_entry_number;
          pay_nxt     = in_entry_payload;
          status_nxt  = ST_OK;
          rnum_nxt    = '0;
          rpay_nxt    = '0;
          wr_pend_nxt = 1'b0;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else if (pos_ext > cnt_ext) begin
              status_nxt = ST_BOUNDS;
              state_nxt  = S_DONE;
            end else begin
              rem_nxt    = CW'(cnt_ext - pos_ext);
              rd_idx_nxt = cnt_m1[AW-1:0];
              state_nxt  = S_MOVE;
            end
          end
          CMD_DELETE: begin
            if (pos_ext >= cnt_ext) begin
              status_nxt = ST_BOUNDS;
              state_nxt  = S_DONE;
            end else begin
              rem_nxt    = CW'(cnt_ext - pos_p1);
              rd_idx_nxt = pos_p1[AW-1:0];
              state_nxt  = S_MOVE;
            end
          end
          CMD_READ: begin
            if (pos_ext >= cnt_ext) begin
              status_nxt = ST_BOUNDS;
              state_nxt  = S_DONE;
            end else begin
              state_nxt  = S_READ;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MOVE: begin
        // pipelined shift: read one entry, write it one slot over next cycle
        ram_we = wr_pend_r;
        if (rem_r != '0) begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = is_ins ? rd_idx_r + 1'b1 : rd_idx_r - 1'b1;
          rd_idx_nxt  = is_ins ? rd_idx_r - 1'b1 : rd_idx_r + 1'b1;
          rem_nxt     = rem_r - 1'b1;
        end else begin
          wr_pend_nxt = 1'b0;
          state_nxt   = is_ins ? S_PLACE : S_DONE;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_addr;
        ram_wdata = {num_r, pay_r};
        state_nxt = S_DONE;
      end
      S_READ: begin
        ram_raddr = pos_addr;
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        rnum_nxt  = ram_rdata[ENTRY_W-1:PAY_W];
        rpay_nxt  = ram_rdata[PAY_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status_r == ST_OK) begin
          if (cmd_r == CMD_INSERT) begin
            count_nxt = count_r + 1'b1;
          end else if (cmd_r == CMD_DELETE) begin
            count_nxt = count_r - 1'b1;
          end
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_status_r <= status_r;
      out_rnum_r   <= rnum_r;
      out_rpay_r   <= rpay_r;
      out_count_r  <= CNT_OUT_W'(count_nxt);
      out_empty_r  <= (count_nxt == '0);
      out_last_r   <= last_ext[CNT_OUT_W-1:0];
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_number   = out_rnum_r;
  assign out_read_payload  = out_rpay_r;
  assign out_count         = out_count_r;
  assign out_is_empty      = out_empty_r;
  assign out_last_position = out_last_r;

`include "indexed_array_list_unit_assert.svh"

  `IAU_CHK_NOW(a_valid_idle, out_valid_r, state_r == S_IDLE, "result strobe while busy")
  `IAU_CHK_NOW(a_count_range, 1'b1, count_r <= CW'(DEPTH), "entry count past depth")
  `IAU_CHK_NEXT(a_accept_eval, start && !busy, state_r == S_EVAL, "accepted command not evaluated")
  `IAU_CHK_NOW(a_idle_no_write, state_r == S_IDLE, !ram_we, "entry RAM written while idle")

endmodule

`default_nettype wire
